### src/nearest_prototype_trainer_macros.svh
// assertion helpers shared by the prototype trainer rtl
`ifndef NEAREST_PROTOTYPE_TRAINER_MACROS_SVH
`define NEAREST_PROTOTYPE_TRAINER_MACROS_SVH

// antecedent and consequent in the same cycle
`define NPT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent in the cycle after the antecedent
`define NPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/npt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package npt_pkg;

   // fixed field widths of the stream items
   localparam int unsigned INPUT_COMPONENTS = 4;
   localparam int unsigned FIELD_COMP_BITS  = 16;
   localparam int unsigned INDEX_BITS       = 4;
   localparam int unsigned TAG_BITS         = 16;
   localparam int unsigned DIST_BITS        = 34;
   localparam int unsigned OP_BITS          = 2;

   // packing of req_tdata and rsp_tdata
   localparam int unsigned REQ_TDATA_BITS = 88;
   localparam int unsigned REQ_COMP_LSB   = INDEX_BITS;
   localparam int unsigned REQ_TAG_LSB    = INDEX_BITS + INPUT_COMPONENTS * FIELD_COMP_BITS;
   localparam int unsigned RSP_TDATA_BITS = 56;
   localparam int unsigned RSP_PAD_BITS   = RSP_TDATA_BITS - INDEX_BITS - DIST_BITS - TAG_BITS;

   // configuration registers
   localparam int unsigned RATE_BITS      = 9;
   localparam int unsigned COUNT_CFG_BITS = 5;
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 9;

   localparam logic [RATE_BITS-1:0]      RATE_RESET     = 9'd179;
   localparam logic [RATE_BITS-1:0]      RATE_ONE       = 9'd256;
   localparam logic [COUNT_CFG_BITS-1:0] CLUSTERS_RESET = 5'd16;

   // rounding offsets of the q1.8 rate product, for a step up and a step down toward the input
   localparam int unsigned FRAC_BITS  = 8;
   localparam int unsigned ROUND_UP   = 128;
   localparam int unsigned ROUND_DOWN = 127;

   typedef enum logic [OP_BITS-1:0] {
      OP_LOAD     = 2'd0,
      OP_TRAIN    = 2'd1,
      OP_CLASSIFY = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LEARNING_RATE   = 2'd0,
      CSR_CLUSTERS_IN_USE = 2'd1
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_SCALE  = 5'b00100,
      ST_WRITE  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

`default_nettype wire

### src/nearest_prototype_trainer.sv
`timescale 1ns / 1ps
`default_nettype none
// nearest_prototype_trainer: winner-take-all vector quantizer over a prototype memory
// load: the row is written into the memory at acceptance, the block stays idle for the next item, no result
// classify: rows pass the memory read, stage 2 and stage 3, then ST_FINISH posts the result and the next item is taken
// train: as classify, with ST_SCALE and ST_WRITE between the scan and ST_FINISH
// n rows searched (clusters_in_use held to 1..CLUSTERS), one per cycle; a held result stalls ST_FINISH
// reset: synchronous, active high; prototype memory is not cleared and must be loaded first

`include "nearest_prototype_trainer_macros.svh"

module nearest_prototype_trainer #(
   parameter int unsigned CLUSTERS       = 16,
   parameter int unsigned VECTOR_DIM     = 4,
   parameter int unsigned COMPONENT_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,

   // input items
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // prototype_index, component_0, component_1, component_2, component_3, pattern_tag
   input  wire logic [npt_pkg::REQ_TDATA_BITS-1:0]     req_tdata,
   // operation
   input  wire logic [npt_pkg::OP_BITS-1:0]            req_tuser,

   // result items
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // nearest_cluster, nearest_distance, result_tag
   output logic [npt_pkg::RSP_TDATA_BITS-1:0]          rsp_tdata,
   // was_training
   output logic                                        rsp_tuser,

   // register writes
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [npt_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [npt_pkg::CSR_DATA_BITS-1:0]      csr_data
);

   // components never exceed the 16-bit input field, so arithmetic uses the smaller of COMPONENT_BITS and 16
   localparam int unsigned CALC_BITS = (COMPONENT_BITS < npt_pkg::FIELD_COMP_BITS) ?
                                       COMPONENT_BITS : npt_pkg::FIELD_COMP_BITS;
   // lanes past the fourth always hold zero and drop out of the distance
   localparam int unsigned LANES = (VECTOR_DIM < npt_pkg::INPUT_COMPONENTS) ?
                                   VECTOR_DIM : npt_pkg::INPUT_COMPONENTS;
   localparam int unsigned IDX_W   = $clog2(CLUSTERS);
   localparam int unsigned CNT_W   = $clog2(CLUSTERS + 1);
   localparam int unsigned SQ_W    = 2 * CALC_BITS;
   localparam int unsigned DIST_W  = SQ_W + 2;
   localparam int unsigned RATE_W  = npt_pkg::RATE_BITS;
   localparam int unsigned PROD_W  = CALC_BITS + RATE_W;
   localparam int unsigned ROW_W   = VECTOR_DIM * COMPONENT_BITS;
   localparam int unsigned FCOMP_W = npt_pkg::FIELD_COMP_BITS;
   localparam int unsigned IDXF_W  = npt_pkg::INDEX_BITS;
   localparam int unsigned DISTF_W = npt_pkg::DIST_BITS;
   localparam int unsigned TAG_W   = npt_pkg::TAG_BITS;
   localparam int unsigned CCFG_W  = npt_pkg::COUNT_CFG_BITS;
   localparam int unsigned PAD_W   = npt_pkg::RSP_PAD_BITS;
   localparam int unsigned COMP_LSB = npt_pkg::REQ_COMP_LSB;
   localparam int unsigned TAG_LSB  = npt_pkg::REQ_TAG_LSB;
   localparam int unsigned FRAC_W   = npt_pkg::FRAC_BITS;

   // ---------------------------------------------------------------
   // state
   // ---------------------------------------------------------------
   npt_pkg::state_type state_ff, state_in;

   logic [RATE_W-1:0]   rate_ff, rate_in;           // learning_rate
   logic [CCFG_W-1:0]   clusters_ff, clusters_in;   // clusters_in_use

   // the item under work
   logic [CALC_BITS-1:0] x_ff [LANES];
   logic [CALC_BITS-1:0] x_in [LANES];
   logic                 train_ff, train_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;        // next row to read

   // prototype memory, one row per prototype, registered read
   logic [ROW_W-1:0]     proto_mem_ff [CLUSTERS];
   logic [ROW_W-1:0]     rd_row_ff;

   // stage 1: row out of the memory
   logic                 valid_s1_ff, valid_s1_in;
   logic                 last_s1_ff, last_s1_in;
   logic [IDX_W-1:0]     idx_s1_ff, idx_s1_in;

   // stage 2: squared component differences
   logic                 valid_s2_ff, valid_s2_in;
   logic                 last_s2_ff, last_s2_in;
   logic [IDX_W-1:0]     idx_s2_ff, idx_s2_in;
   logic [SQ_W-1:0]      sq_s2_ff [LANES];
   logic [SQ_W-1:0]      sq_s2_in [LANES];
   logic [CALC_BITS-1:0] w_s2_ff [LANES];
   logic [CALC_BITS-1:0] w_s2_in [LANES];

   // stage 3: summed distance
   logic                 valid_s3_ff, valid_s3_in;
   logic                 last_s3_ff, last_s3_in;
   logic [IDX_W-1:0]     idx_s3_ff, idx_s3_in;
   logic [DIST_W-1:0]    dist_s3_ff, dist_s3_in;
   logic [CALC_BITS-1:0] w_s3_ff [LANES];
   logic [CALC_BITS-1:0] w_s3_in [LANES];

   // running winner, its row is kept so the update needs no second read
   logic [DIST_W-1:0]    best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [CALC_BITS-1:0] best_w_ff [LANES];
   logic [CALC_BITS-1:0] best_w_in [LANES];

   // update: rate times the distance to the input, per lane
   logic [PROD_W-1:0]    prod_ff [LANES];
   logic [PROD_W-1:0]    prod_in [LANES];
   logic                 up_ff [LANES];             // input at or above the prototype
   logic                 up_in [LANES];

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDXF_W-1:0]    rsp_cluster_ff, rsp_cluster_in;
   logic [DISTF_W-1:0]   rsp_dist_ff, rsp_dist_in;
   logic [TAG_W-1:0]     rsp_tag_ff, rsp_tag_in;
   logic                 rsp_train_ff, rsp_train_in;

   // ---------------------------------------------------------------
   // combinational helpers
   // ---------------------------------------------------------------
   logic                  accept;
   logic                  rsp_free;
   npt_pkg::op_type       req_op;
   logic [IDXF_W-1:0]     req_index;
   logic                  load_in_range;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [ROW_W-1:0]      mem_wdata;
   logic [CNT_W-1:0]      count_sel;
   logic                  better;
   logic [RATE_W-1:0]     rate_eff;
   logic [CALC_BITS-1:0]  diff_s1 [LANES];
   logic [CALC_BITS-1:0]  mag_sc [LANES];
   logic [PROD_W:0]       round_wr [LANES];
   logic [CALC_BITS-1:0]  step_wr [LANES];
   logic [CALC_BITS-1:0]  new_w_wr [LANES];

   assign accept    = req_tvalid && req_tready;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign req_op    = npt_pkg::op_type'(req_tuser);
   assign req_index = req_tdata[IDXF_W-1:0];

   assign load_in_range = 32'(req_index) < CLUSTERS;

   // sequential: only an idle block takes an item, a waiting result does not block it
   assign req_tready = (state_ff == npt_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;

   assign rd_en   = (state_ff == npt_pkg::ST_SCAN) && (issue_ff < count_ff);
   assign rd_addr = issue_ff[IDX_W-1:0];

   // clusters_in_use of zero searches one prototype, above the bank size the whole bank
   always_comb begin
      if (clusters_ff == '0) begin
         count_sel = CNT_W'(1);
      end else if (32'(clusters_ff) > CLUSTERS) begin
         count_sel = CNT_W'(CLUSTERS);
      end else begin
         count_sel = CNT_W'(clusters_ff);
      end
   end

   assign rate_eff = (rate_ff > npt_pkg::RATE_ONE) ? npt_pkg::RATE_ONE : rate_ff;

   // first row always wins, later rows only on a strictly smaller distance
   assign better = valid_s3_ff && ((idx_s3_ff == '0) || (dist_s3_ff < best_dist_ff));

   // per lane arithmetic
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         // absolute difference against the row leaving the memory
         if (x_ff[i] >= rd_row_ff[i*COMPONENT_BITS +: CALC_BITS]) begin
            diff_s1[i] = x_ff[i] - rd_row_ff[i*COMPONENT_BITS +: CALC_BITS];
         end else begin
            diff_s1[i] = rd_row_ff[i*COMPONENT_BITS +: CALC_BITS] - x_ff[i];
         end
         // distance from the winner to the input
         if (x_ff[i] >= best_w_ff[i]) begin
            mag_sc[i] = x_ff[i] - best_w_ff[i];
         end else begin
            mag_sc[i] = best_w_ff[i] - x_ff[i];
         end
         // round half up for an upward step, and half down in magnitude for a downward step
         if (up_ff[i]) begin
            round_wr[i] = {1'b0, prod_ff[i]} + (PROD_W + 1)'(npt_pkg::ROUND_UP);
         end else begin
            round_wr[i] = {1'b0, prod_ff[i]} + (PROD_W + 1)'(npt_pkg::ROUND_DOWN);
         end
         step_wr[i] = CALC_BITS'(round_wr[i] >> FRAC_W);
         // the step never exceeds the distance, so no wrap either way
         if (up_ff[i]) begin
            new_w_wr[i] = best_w_ff[i] + step_wr[i];
         end else begin
            new_w_wr[i] = best_w_ff[i] - step_wr[i];
         end
      end
   end

   // memory write: a load straight from the item, or the trained winner
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = best_idx_ff;
      mem_wdata = '0;
      if (state_ff == npt_pkg::ST_WRITE) begin
         mem_we = 1'b1;
         for (int i = 0; i < LANES; i++) begin
            mem_wdata[i*COMPONENT_BITS +: COMPONENT_BITS] = COMPONENT_BITS'(new_w_wr[i]);
         end
      end else begin
         mem_we    = accept && (req_op == npt_pkg::OP_LOAD) && load_in_range;
         mem_waddr = IDX_W'(req_index);
         for (int i = 0; i < LANES; i++) begin
            mem_wdata[i*COMPONENT_BITS +: COMPONENT_BITS] =
               COMPONENT_BITS'(CALC_BITS'(req_tdata[COMP_LSB + i*FCOMP_W +: FCOMP_W]));
         end
      end
   end

   // ---------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      rate_in      = rate_ff;
      clusters_in  = clusters_ff;
      train_in     = train_ff;
      tag_in       = tag_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_cluster_in = rsp_cluster_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_train_in   = rsp_train_ff;

      // register writes are to arrive only while idle; the block itself does not enforce it
      if (csr_valid) begin
         unique case (npt_pkg::csr_index_type'(csr_index))
            npt_pkg::CSR_LEARNING_RATE:   rate_in     = RATE_W'(csr_data);
            npt_pkg::CSR_CLUSTERS_IN_USE: clusters_in = CCFG_W'(csr_data);
            default: ;
         endcase
      end

      for (int i = 0; i < LANES; i++) begin
         x_in[i]      = x_ff[i];
         sq_s2_in[i]  = CALC_BITS'(diff_s1[i]) * CALC_BITS'(diff_s1[i]);
         w_s2_in[i]   = rd_row_ff[i*COMPONENT_BITS +: CALC_BITS];
         w_s3_in[i]   = w_s2_ff[i];
         best_w_in[i] = better ? w_s3_ff[i] : best_w_ff[i];
         up_in[i]     = x_ff[i] >= best_w_ff[i];
         prod_in[i]   = PROD_W'(rate_eff) * PROD_W'(mag_sc[i]);
      end

      // read pipeline
      valid_s1_in = rd_en;
      last_s1_in  = rd_en && (issue_ff == count_ff - CNT_W'(1));
      idx_s1_in   = rd_addr;
      valid_s2_in = valid_s1_ff;
      last_s2_in  = last_s1_ff;
      idx_s2_in   = idx_s1_ff;
      valid_s3_in = valid_s2_ff;
      last_s3_in  = last_s2_ff;
      idx_s3_in   = idx_s2_ff;
      dist_s3_in  = '0;
      for (int i = 0; i < LANES; i++) begin
         dist_s3_in = dist_s3_in + DIST_W'(sq_s2_ff[i]);
      end

      if (better) begin
         best_dist_in = dist_s3_ff;
         best_idx_in  = idx_s3_ff;
      end

      unique case (state_ff)
         npt_pkg::ST_IDLE: begin
            if (accept) begin
               for (int i = 0; i < LANES; i++) begin
                  x_in[i] = CALC_BITS'(req_tdata[COMP_LSB + i*FCOMP_W +: FCOMP_W]);
               end
               tag_in   = req_tdata[TAG_LSB +: TAG_W];
               train_in = (req_op == npt_pkg::OP_TRAIN);
               count_in = count_sel;
               issue_in = '0;
               case (req_op) inside
                  npt_pkg::OP_TRAIN, npt_pkg::OP_CLASSIFY: state_in = npt_pkg::ST_SCAN;
                  default: ;   // loads finish at acceptance, the unused code is dropped
               endcase
            end
         end
         npt_pkg::ST_SCAN: begin
            if (rd_en) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            if (valid_s3_ff && last_s3_ff) begin
               state_in = train_ff ? npt_pkg::ST_SCALE : npt_pkg::ST_FINISH;
            end
         end
         npt_pkg::ST_SCALE: begin
            state_in = npt_pkg::ST_WRITE;
         end
         npt_pkg::ST_WRITE: begin
            state_in = npt_pkg::ST_FINISH;
         end
         npt_pkg::ST_FINISH: begin
            // wait for the result register to empty
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_cluster_in = IDXF_W'(best_idx_ff);
               rsp_dist_in    = DISTF_W'(best_dist_ff);
               rsp_tag_in     = tag_ff;
               rsp_train_in   = train_ff;
               state_in       = npt_pkg::ST_IDLE;
            end
         end
         default: state_in = npt_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= npt_pkg::ST_IDLE;
         rate_ff      <= npt_pkg::RATE_RESET;
         clusters_ff  <= npt_pkg::CLUSTERS_RESET;
         issue_ff     <= '0;
         valid_s1_ff  <= 1'b0;
         valid_s2_ff  <= 1'b0;
         valid_s3_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         clusters_ff  <= clusters_in;
         issue_ff     <= issue_in;
         valid_s1_ff  <= valid_s1_in;
         valid_s2_ff  <= valid_s2_in;
         valid_s3_ff  <= valid_s3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      train_ff       <= train_in;
      tag_ff         <= tag_in;
      count_ff       <= count_in;
      last_s1_ff     <= last_s1_in;
      idx_s1_ff      <= idx_s1_in;
      last_s2_ff     <= last_s2_in;
      idx_s2_ff      <= idx_s2_in;
      last_s3_ff     <= last_s3_in;
      idx_s3_ff      <= idx_s3_in;
      dist_s3_ff     <= dist_s3_in;
      best_dist_ff   <= best_dist_in;
      best_idx_ff    <= best_idx_in;
      rsp_cluster_ff <= rsp_cluster_in;
      rsp_dist_ff    <= rsp_dist_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_train_ff   <= rsp_train_in;
      for (int i = 0; i < LANES; i++) begin
         x_ff[i]      <= x_in[i];
         sq_s2_ff[i]  <= sq_s2_in[i];
         w_s2_ff[i]   <= w_s2_in[i];
         w_s3_ff[i]   <= w_s3_in[i];
         best_w_ff[i] <= best_w_in[i];
         prod_ff[i]   <= prod_in[i];
         up_ff[i]     <= up_in[i];
      end
   end

   // prototype memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         proto_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_row_ff <= proto_mem_ff[rd_addr];
      end
   end

   // ---------------------------------------------------------------
   // outputs
   // ---------------------------------------------------------------
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {PAD_W'(0), rsp_tag_ff, rsp_dist_ff, rsp_cluster_ff};
   assign rsp_tuser  = rsp_train_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   `NPT_ASSERT_SAME(a_no_write_during_scan, mem_we, state_ff != npt_pkg::ST_SCAN,
                    "prototype memory written while the scan reads it")
   `NPT_ASSERT_SAME(a_winner_in_search_range, state_ff == npt_pkg::ST_WRITE,
                    CNT_W'(best_idx_ff) < count_ff, "trained prototype outside the searched range")
   `NPT_ASSERT_SAME(a_pipe_busy_only_in_scan, valid_s1_ff || valid_s2_ff || valid_s3_ff,
                    state_ff == npt_pkg::ST_SCAN, "distance pipeline active outside the scan")
   `NPT_ASSERT_NEXT(a_result_posted, state_ff == npt_pkg::ST_FINISH && rsp_free,
                    rsp_valid_ff, "finished item did not reach the result register")

endmodule

`default_nettype wire

### tb/tb_nearest_prototype_trainer.sv
`timescale 1ns / 1ps

module tb_nearest_prototype_trainer;

   localparam int unsigned CLOCK_PERIOD  = 20;
   localparam int unsigned PROTOTYPES    = 16;
   // settle time after the queues drain, so this covers any trailing work
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned MAX_WAIT      = 18;
   localparam int unsigned PRINT_LIMIT   = 40;

   // the one operation code with no enum member: the block must drop it silently
   localparam logic [npt_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;

   typedef logic [npt_pkg::INPUT_COMPONENTS-1:0][npt_pkg::FIELD_COMP_BITS-1:0] vector_type;

   // one input item as the stimulus side sees it
   typedef struct {
      logic [npt_pkg::OP_BITS-1:0]    op;
      logic [npt_pkg::INDEX_BITS-1:0] index;
      vector_type                     comp;
      logic [npt_pkg::TAG_BITS-1:0]   tag;
   } train_item_type;

   // one expected result item
   typedef struct {
      logic [npt_pkg::INDEX_BITS-1:0] cluster;
      logic [npt_pkg::DIST_BITS-1:0]  distance;
      logic [npt_pkg::TAG_BITS-1:0]   tag;
      logic                           training;
   } nearest_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   // prototype_index, component_0..3, pattern_tag, zero pad
   logic [npt_pkg::REQ_TDATA_BITS-1:0] req_tdata = '0;
   // operation
   logic [npt_pkg::OP_BITS-1:0]        req_tuser = '0;

   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   // nearest_cluster, nearest_distance, result_tag, zero pad
   logic [npt_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   // was_training
   logic                               rsp_tuser;

   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [npt_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [npt_pkg::CSR_DATA_BITS-1:0]  csr_data = '0;

   // handshakes seen at the last rising edge, for the falling-edge drivers
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic csr_fire = 1'b0;

   // pacing of both sides; a calm side runs without gaps for a while
   int unsigned req_gap   = 0;
   int unsigned rsp_hold  = 0;
   bit          req_calm  = 1'b0;
   bit          rsp_calm  = 1'b0;

   train_item_type     req_cur;
   train_item_type     item_queue [$];
   nearest_result_type result_queue [$];

   // predictor state: prototype bank and register copies
   vector_type                         codebook [PROTOTYPES];
   logic [npt_pkg::RATE_BITS-1:0]      cur_rate = npt_pkg::RATE_RESET;
   logic [npt_pkg::COUNT_CFG_BITS-1:0] cur_span = npt_pkg::CLUSTERS_RESET;

   // what the stimulus believes is loaded, used to aim items near prototypes
   vector_type shape_w [PROTOTYPES] = '{default: '0};

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   nearest_prototype_trainer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- helpers

   function automatic int unsigned draw_wait(input bit calm);
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic logic [npt_pkg::REQ_TDATA_BITS-1:0] pack_req(input train_item_type it);
      logic [npt_pkg::REQ_TDATA_BITS-1:0] word;
      word = '0;
      word[0 +: npt_pkg::INDEX_BITS] = it.index;
      word[npt_pkg::REQ_COMP_LSB +: npt_pkg::INPUT_COMPONENTS * npt_pkg::FIELD_COMP_BITS] =
         it.comp;
      word[npt_pkg::REQ_TAG_LSB +: npt_pkg::TAG_BITS] = it.tag;
      return word;
   endfunction

   // squared euclidean distance, exact in 64 bits at these widths
   function automatic longint sq_distance(input vector_type a, input vector_type b);
      longint total;
      longint d;
      int     k;
      total = 0;
      for (k = 0; k < npt_pkg::INPUT_COMPONENTS; k++) begin
         d = longint'(a[k]) - longint'(b[k]);
         total += d * d;
      end
      return total;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < PRINT_LIMIT)
         $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
      error_count++;
   endtask

   // predictor: runs once per accepted item, in acceptance order
   task automatic predict_nearest(input train_item_type it);
      int unsigned        span;
      int unsigned        j;
      int unsigned        k;
      int unsigned        winner;
      longint             best;
      longint             row_distance;
      longint             rate;
      longint             diff;
      longint             nudge;
      nearest_result_type res;
      if (it.op == npt_pkg::OP_LOAD) begin
         codebook[it.index] = it.comp;
      end else if (it.op != OP_UNUSED) begin
         // zero clusters means one, anything past the bank means the whole bank
         span = (cur_span == 0) ? 1 : ((cur_span > PROTOTYPES) ? PROTOTYPES : cur_span);
         winner = 0;
         best = sq_distance(it.comp, codebook[0]);
         // strict compare keeps the lowest index on ties
         for (j = 1; j < span; j++) begin
            row_distance = sq_distance(it.comp, codebook[j]);
            if (row_distance < best) begin
               best = row_distance;
               winner = j;
            end
         end
         res.cluster  = npt_pkg::INDEX_BITS'(winner);
         res.distance = npt_pkg::DIST_BITS'(best);
         res.tag      = it.tag;
         res.training = (it.op == npt_pkg::OP_TRAIN);
         if (it.op == npt_pkg::OP_TRAIN) begin
            // rate saturates at one; step is floor((rate * diff + half) / 256)
            rate = (cur_rate > npt_pkg::RATE_ONE) ? npt_pkg::RATE_ONE : cur_rate;
            for (k = 0; k < npt_pkg::INPUT_COMPONENTS; k++) begin
               diff  = longint'(it.comp[k]) - longint'(codebook[winner][k]);
               nudge = (diff * rate + longint'(npt_pkg::ROUND_UP)) >>> npt_pkg::FRAC_BITS;
               codebook[winner][k] =
                  npt_pkg::FIELD_COMP_BITS'(longint'(codebook[winner][k]) + nudge);
            end
         end
         result_queue.push_back(res);
      end
   endtask

   // ---------------------------------------------------------------- stimulus building

   task automatic queue_item(input logic [npt_pkg::OP_BITS-1:0] op,
                             input logic [npt_pkg::INDEX_BITS-1:0] idx,
                             input vector_type v, input logic [npt_pkg::TAG_BITS-1:0] tag);
      train_item_type it;
      it.op    = op;
      it.index = idx;
      it.comp  = v;
      it.tag   = tag;
      item_queue.push_back(it);
      if (op == npt_pkg::OP_LOAD)
         shape_w[idx] = v;
   endtask

   // mix of uniform, near-prototype, corner and exact-hit vectors
   task automatic make_vector(output vector_type v);
      int unsigned style;
      int unsigned src;
      int unsigned k;
      int          noisy;
      style = $urandom_range(0, 5);
      src   = $urandom_range(0, PROTOTYPES - 1);
      for (k = 0; k < npt_pkg::INPUT_COMPONENTS; k++) begin
         case (style)
            0, 1: v[k] = npt_pkg::FIELD_COMP_BITS'($urandom);
            2, 3: begin
               noisy = int'(shape_w[src][k]) + int'($urandom_range(0, 512)) - 256;
               if (noisy < 0)
                  noisy = 0;
               else if (noisy > 65535)
                  noisy = 65535;
               v[k] = npt_pkg::FIELD_COMP_BITS'(noisy);
            end
            4: v[k] = $urandom_range(0, 1) ? '1 : '0;
            default: v[k] = shape_w[src][k];
         endcase
      end
   endtask

   task automatic csr_write(input logic [npt_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [npt_pkg::CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(negedge clock); while (!csr_fire);
      csr_valid <= 1'b0;
   endtask

   // idle means: nothing queued, nothing on the bus, no result outstanding
   task automatic wait_idle();
      do @(posedge clock);
      while (item_queue.size() != 0 || req_tvalid || result_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one register setting, then a random mix of operations
   task automatic train_phase(input logic [npt_pkg::RATE_BITS-1:0] rate,
                              input logic [npt_pkg::COUNT_CFG_BITS-1:0] span,
                              input int unsigned n);
      int unsigned made;
      int unsigned pick;
      vector_type  v;
      csr_write(npt_pkg::CSR_LEARNING_RATE, rate);
      csr_write(npt_pkg::CSR_CLUSTERS_IN_USE, npt_pkg::CSR_DATA_BITS'(span));
      made = 0;
      while (made < n) begin
         pick = $urandom_range(0, 99);
         make_vector(v);
         if (pick < 20) begin
            // some loads duplicate another prototype to force ties
            if ($urandom_range(0, 3) == 0)
               v = shape_w[$urandom_range(0, PROTOTYPES - 1)];
            queue_item(npt_pkg::OP_LOAD, npt_pkg::INDEX_BITS'($urandom), v,
                       npt_pkg::TAG_BITS'($urandom));
            made++;
         end else if (pick < 60) begin
            queue_item(npt_pkg::OP_TRAIN, npt_pkg::INDEX_BITS'($urandom), v,
                       npt_pkg::TAG_BITS'($urandom));
            made++;
         end else if (pick < 95) begin
            queue_item(npt_pkg::OP_CLASSIFY, npt_pkg::INDEX_BITS'($urandom), v,
                       npt_pkg::TAG_BITS'($urandom));
            made++;
         end else begin
            queue_item(OP_UNUSED, npt_pkg::INDEX_BITS'($urandom), v,
                       npt_pkg::TAG_BITS'($urandom));
         end
      end
      wait_idle();
   endtask

   // ---------------------------------------------------------------- drivers

   // input side: items change on the falling edge, valid held across back-to-back items
   always @(negedge clock) begin : drive_req
      train_item_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap != 0) begin
            req_gap    <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (item_queue.size() != 0) begin
            next_item = item_queue.pop_front();
            req_cur    <= next_item;
            req_tdata  <= pack_req(next_item);
            req_tuser  <= next_item.op;
            req_tvalid <= 1'b1;
            req_gap    <= draw_wait(req_calm);
            if ($urandom_range(0, 39) == 0)
               req_calm <= ~req_calm;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side: after each taken item, stall for a random number of cycles, none while calm
   always @(negedge clock) begin : drive_rsp
      int unsigned hold;
      if (rsp_fire) begin
         hold = draw_wait(rsp_calm);
         rsp_tready <= (hold == 0);
         rsp_hold   <= (hold == 0) ? 0 : hold - 1;
         if ($urandom_range(0, 39) == 0)
            rsp_calm <= ~rsp_calm;
      end else if (rsp_hold != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : watch
      nearest_result_type want;
      req_fire <= !reset && req_tvalid && req_tready;
      rsp_fire <= !reset && rsp_tvalid && rsp_tready;
      csr_fire <= !reset && csr_valid && csr_ready;
      if (!reset) begin
         // register writes land in the predictor copy at acceptance
         if (csr_valid && csr_ready) begin
            case (csr_index)
               npt_pkg::CSR_LEARNING_RATE:   cur_rate = csr_data;
               npt_pkg::CSR_CLUSTERS_IN_USE: cur_span = csr_data[npt_pkg::COUNT_CFG_BITS-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_nearest(req_cur);
         if (rsp_tvalid && rsp_tready) begin
            if (result_queue.size() == 0) begin
               report_mismatch("unexpected result item", rsp_tdata, '0);
            end else begin
               want = result_queue.pop_front();
               if (rsp_tdata[0 +: npt_pkg::INDEX_BITS] !== want.cluster)
                  report_mismatch("nearest_cluster", rsp_tdata[0 +: npt_pkg::INDEX_BITS],
                                  want.cluster);
               if (rsp_tdata[npt_pkg::INDEX_BITS +: npt_pkg::DIST_BITS] !== want.distance)
                  report_mismatch("nearest_distance",
                                  rsp_tdata[npt_pkg::INDEX_BITS +: npt_pkg::DIST_BITS],
                                  want.distance);
               if (rsp_tdata[npt_pkg::INDEX_BITS + npt_pkg::DIST_BITS +: npt_pkg::TAG_BITS]
                   !== want.tag)
                  report_mismatch("result_tag",
                     rsp_tdata[npt_pkg::INDEX_BITS + npt_pkg::DIST_BITS +: npt_pkg::TAG_BITS],
                     want.tag);
               if (rsp_tuser !== want.training)
                  report_mismatch("was_training", rsp_tuser, want.training);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------- test sequence

   initial begin : sequence_main
      int unsigned k;
      vector_type  v;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed part at reset settings: fill the whole bank first so no empty row is read
      queue_item(npt_pkg::OP_LOAD, 4'd0, '0, 16'h0000);
      for (k = 1; k < PROTOTYPES - 1; k++) begin
         v = {$urandom, $urandom};
         queue_item(npt_pkg::OP_LOAD, npt_pkg::INDEX_BITS'(k), v, npt_pkg::TAG_BITS'($urandom));
      end
      queue_item(npt_pkg::OP_LOAD, 4'd15, '1, 16'hFFFF);
      // duplicate row: exact match on both must pick the lower index
      queue_item(npt_pkg::OP_LOAD, 4'd9, shape_w[3], npt_pkg::TAG_BITS'($urandom));
      queue_item(npt_pkg::OP_CLASSIFY, 4'd0, '0, 16'h0000);
      queue_item(npt_pkg::OP_CLASSIFY, 4'd15, '1, 16'hFFFF);
      queue_item(npt_pkg::OP_CLASSIFY, 4'd5, shape_w[3], npt_pkg::TAG_BITS'($urandom));
      // unused operation: no result, no state change
      queue_item(OP_UNUSED, 4'd7, {$urandom, $urandom}, npt_pkg::TAG_BITS'($urandom));
      // train just below the all-ones row, then just off the zero row
      queue_item(npt_pkg::OP_TRAIN, 4'd0, {4{16'hFFFE}}, npt_pkg::TAG_BITS'($urandom));
      queue_item(npt_pkg::OP_TRAIN, 4'd15, {16'd1, 16'd0, 16'd0, 16'd0},
                 npt_pkg::TAG_BITS'($urandom));
      queue_item(npt_pkg::OP_CLASSIFY, 4'd3, '0, npt_pkg::TAG_BITS'($urandom));
      queue_item(npt_pkg::OP_CLASSIFY, 4'd12, {4{16'hFFFE}}, npt_pkg::TAG_BITS'($urandom));
      wait_idle();

      // random part over several settings, extremes and out-of-range values included
      train_phase(npt_pkg::RATE_ONE, 5'd16, 100);
      train_phase(9'd0, 5'd1, 100);
      train_phase(9'd511, 5'd31, 100);
      train_phase(9'd1, 5'd0, 100);
      train_phase(9'd128, 5'd8, 100);
      train_phase(9'd300, 5'd2, 100);
      train_phase(npt_pkg::RATE_BITS'($urandom_range(2, 255)),
                  npt_pkg::COUNT_CFG_BITS'($urandom_range(1, 31)), 100);
      train_phase(npt_pkg::RATE_RESET, 5'd15, 100);
      train_phase(9'd255, npt_pkg::CLUSTERS_RESET, 100);
      train_phase(npt_pkg::RATE_BITS'($urandom_range(257, 511)), 5'd4, 100);

      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
